>>> hdl/bgd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgd_pkg
// Types, constants and helper functions shared by the gravity derivative block.
// ----------------------------------------------------------------------------
package bgd_pkg;

	localparam int BODY_N    = 3;
	localparam int PAIR_N    = 3;
	localparam int SQ_STEPS  = 32;
	localparam int DIV_STEPS = 32;
	// lane stages: delta, leading one, scale, square, sum, root, products,
	// three divides, exponent, sign
	localparam int LANE_LAT  = 5 + SQ_STEPS + 1 + 3 * DIV_STEPS + 2;

	// 4*pi^2 in Q6.26
	localparam logic [31:0] G_Q626  = 32'd2649351758;
	localparam logic [47:0] MAG_CAP = 48'h8000_0000_0000;

	typedef logic signed [47:0] pos_t;

	typedef struct packed {
		pos_t body0_x;
		pos_t body0_y;
		pos_t body1_x;
		pos_t body1_y;
		pos_t body2_x;
		pos_t body2_y;
		pos_t body0_vx;
		pos_t body0_vy;
		pos_t body1_vx;
		pos_t body1_vy;
		pos_t body2_vx;
		pos_t body2_vy;
	} item_t;

	typedef struct packed {
		pos_t body0_dx;
		pos_t body0_dy;
		pos_t body1_dx;
		pos_t body1_dy;
		pos_t body2_dx;
		pos_t body2_dy;
		pos_t body0_ax;
		pos_t body0_ay;
		pos_t body1_ax;
		pos_t body1_ay;
		pos_t body2_ax;
		pos_t body2_ay;
	} result_t;

	typedef struct packed {
		pos_t vx0;
		pos_t vy0;
		pos_t vx1;
		pos_t vy1;
		pos_t vx2;
		pos_t vy2;
	} vel_t;

	// G*m normalized to a 32-bit mantissa and a left exponent
	typedef struct packed {
		logic        nz;
		logic [5:0]  pe;
		logic [31:0] pm;
	} mass_info_t;

	typedef struct packed {
		logic signed [48:0] ax_a;
		logic signed [48:0] ay_a;
		logic signed [48:0] ax_b;
		logic signed [48:0] ay_b;
		logic               coin_a;
		logic               coin_b;
	} lane_res_t;

	function automatic int pair_a(int p);
		case (p)
			0:       return 0;
			1:       return 0;
			default: return 1;
		endcase
	endfunction

	function automatic int pair_b(int p);
		case (p)
			0:       return 1;
			1:       return 2;
			default: return 2;
		endcase
	endfunction

	function automatic logic [6:0] bitlen64(logic [63:0] v);
		logic [6:0] n;
		n = '0;
		for (int b = 0; b < 64; b++) begin
			if (v[b])
				n = 7'(b + 1);
		end
		return n;
	endfunction

	function automatic mass_info_t make_mass_info(logic [63:0] p);
		mass_info_t mi;
		logic [6:0] bl;
		logic [5:0] pe;
		bl    = bitlen64(p);
		pe    = 6'(bl - 7'd32);
		mi.nz = (p != '0);
		mi.pe = pe;
		mi.pm = 32'(p >> pe);
		return mi;
	endfunction

endpackage

>>> hdl/nbody_gravity_derivative_top.sv
`timescale 1ns / 1ps
// Throughput: one item per cycle; the pair lanes' root and divide pipelines
// take one new item every cycle and the whole pipeline holds on output stall.
// Reset: arst_n clears all valid bits and sets every mass to 1.0 solar mass.
// Mass registers may be written in the cycle after reset is released.
// ----------------------------------------------------------------------------
// nbody_gravity_derivative_top
// Plane three-body state derivative: velocity copy and summed gravity pulls.
// ----------------------------------------------------------------------------
module nbody_gravity_derivative_top import bgd_pkg::*; #(
	parameter int BODY_COUNT = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  item_t       item,
	output logic        result_valid,
	input  logic        result_ready,
	output result_t     result,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam logic [1:0] REG_MASS_BODY0 = 2'd0;
	localparam logic [1:0] REG_MASS_BODY1 = 2'd1;
	localparam logic [1:0] REG_MASS_BODY2 = 2'd2;
	localparam logic [31:0] MASS_ONE = 32'd16777216;
	localparam logic signed [49:0] POS_MAX = 50'sh7FFF_FFFF_FFFF;
	localparam logic signed [49:0] NEG_MIN = -50'sh8000_0000_0000;

	logic en;

	// mass registers and derived G*m
	logic [31:0]  mass_q [BODY_N];
	logic [63:0]  p_q    [BODY_N];
	mass_info_t   mi_q   [BODY_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < BODY_N; b++)
				mass_q[b] <= MASS_ONE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MASS_BODY0: mass_q[0] <= cfg_data;
				REG_MASS_BODY1: mass_q[1] <= cfg_data;
				REG_MASS_BODY2: mass_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		for (int b = 0; b < BODY_N; b++) begin
			p_q[b]  <= 64'(mass_q[b]) * 64'(G_Q626);
			mi_q[b] <= make_mass_info(p_q[b]);
		end
	end

	// input register
	logic  item_vld_q;
	item_t item_q;

	assign en         = ~result_valid | result_ready;
	assign item_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			item_vld_q <= 1'b0;
		else if (en)
			item_vld_q <= item_valid;
	end

	always_ff @(posedge clk) begin
		if (en)
			item_q <= item;
	end

	pos_t pos_x [BODY_N];
	pos_t pos_y [BODY_N];

	assign pos_x[0] = item_q.body0_x;
	assign pos_y[0] = item_q.body0_y;
	assign pos_x[1] = item_q.body1_x;
	assign pos_y[1] = item_q.body1_y;
	assign pos_x[2] = item_q.body2_x;
	assign pos_y[2] = item_q.body2_y;

	// pair lanes
	lane_res_t lres [PAIR_N];

	for (genvar gp = 0; gp < PAIR_N; gp++) begin : g_lane
		localparam int A = pair_a(gp);
		localparam int B = pair_b(gp);
		if (B < BODY_COUNT) begin : g_on
			bgd_lane u_lane (
				.clk  (clk),
				.en   (en),
				.xa   (pos_x[A]),
				.ya   (pos_y[A]),
				.xb   (pos_x[B]),
				.yb   (pos_y[B]),
				.mi_a (mi_q[A]),
				.mi_b (mi_q[B]),
				.res  (lres[gp])
			);
		end else begin : g_off
			assign lres[gp] = '0;
		end
	end

	// velocity and valid delay alongside the lanes
	vel_t vel_q [LANE_LAT];
	logic vld_q [LANE_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			vel_q[0] <= {item_q.body0_vx, item_q.body0_vy, item_q.body1_vx,
				item_q.body1_vy, item_q.body2_vx, item_q.body2_vy};
			for (int s = 1; s < LANE_LAT; s++)
				vel_q[s] <= vel_q[s-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < LANE_LAT; s++)
				vld_q[s] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= item_vld_q;
			for (int s = 1; s < LANE_LAT; s++)
				vld_q[s] <= vld_q[s-1];
		end
	end

	// merge the pair terms per body
	logic signed [49:0] sum_x [BODY_N];
	logic signed [49:0] sum_y [BODY_N];
	logic               coin  [BODY_N];
	pos_t               acc_x [BODY_N];
	pos_t               acc_y [BODY_N];

	function automatic pos_t sat48(logic signed [49:0] v, logic c);
		if (c || v > POS_MAX)
			return 48'(POS_MAX);
		if (v < NEG_MIN)
			return 48'(NEG_MIN);
		return 48'(v);
	endfunction

	always_comb begin
		for (int i = 0; i < BODY_N; i++) begin
			sum_x[i] = '0;
			sum_y[i] = '0;
			coin[i]  = 1'b0;
		end
		for (int p = 0; p < PAIR_N; p++) begin
			sum_x[pair_a(p)] = sum_x[pair_a(p)] + 50'(lres[p].ax_a);
			sum_y[pair_a(p)] = sum_y[pair_a(p)] + 50'(lres[p].ay_a);
			sum_x[pair_b(p)] = sum_x[pair_b(p)] + 50'(lres[p].ax_b);
			sum_y[pair_b(p)] = sum_y[pair_b(p)] + 50'(lres[p].ay_b);
			coin[pair_a(p)]  = coin[pair_a(p)] | lres[p].coin_a;
			coin[pair_b(p)]  = coin[pair_b(p)] | lres[p].coin_b;
		end
		for (int i = 0; i < BODY_N; i++) begin
			acc_x[i] = sat48(sum_x[i], coin[i]);
			acc_y[i] = sat48(sum_y[i], coin[i]);
		end
	end

	// output register
	logic    result_vld_q;
	result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_vld_q <= 1'b0;
		else if (en)
			result_vld_q <= vld_q[LANE_LAT-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_q.body0_dx <= vel_q[LANE_LAT-1].vx0;
			result_q.body0_dy <= vel_q[LANE_LAT-1].vy0;
			result_q.body1_dx <= vel_q[LANE_LAT-1].vx1;
			result_q.body1_dy <= vel_q[LANE_LAT-1].vy1;
			result_q.body2_dx <= vel_q[LANE_LAT-1].vx2;
			result_q.body2_dy <= vel_q[LANE_LAT-1].vy2;
			result_q.body0_ax <= acc_x[0];
			result_q.body0_ay <= acc_y[0];
			result_q.body1_ax <= acc_x[1];
			result_q.body1_ay <= acc_y[1];
			result_q.body2_ax <= acc_x[2];
			result_q.body2_ay <= acc_y[2];
		end
	end

	assign result_valid = result_vld_q;
	assign result       = result_q;

endmodule

>>> hdl/bgd_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgd_isqrt
// Pipelined integer square root, one result bit per stage, with a side tag.
// ----------------------------------------------------------------------------
module bgd_isqrt import bgd_pkg::*; #(
	parameter int TAG_W = 8
) (
	input  logic             clk,
	input  logic             en,
	input  logic [62:0]      rad,
	input  logic [TAG_W-1:0] tag_in,
	output logic [31:0]      root,
	output logic [TAG_W-1:0] tag_out
);

	logic [63:0]      rem_q [SQ_STEPS];
	logic [63:0]      acc_q [SQ_STEPS];
	logic [TAG_W-1:0] tag_q [SQ_STEPS];

	for (genvar s = 0; s < SQ_STEPS; s++) begin : g_step
		localparam logic [63:0] BIT = 64'd1 << (2 * (SQ_STEPS - 1 - s));
		logic [63:0]      rem_i;
		logic [63:0]      acc_i;
		logic [63:0]      trial;
		logic [TAG_W-1:0] tag_i;

		if (s == 0) begin : g_first
			assign rem_i = {1'b0, rad};
			assign acc_i = '0;
			assign tag_i = tag_in;
		end else begin : g_next
			assign rem_i = rem_q[s-1];
			assign acc_i = acc_q[s-1];
			assign tag_i = tag_q[s-1];
		end

		assign trial = acc_i + BIT;

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_i >= trial) begin
					rem_q[s] <= rem_i - trial;
					acc_q[s] <= (acc_i >> 1) + BIT;
				end else begin
					rem_q[s] <= rem_i;
					acc_q[s] <= acc_i >> 1;
				end
				tag_q[s] <= tag_i;
			end
		end
	end

	assign root    = 32'(acc_q[SQ_STEPS-1]);
	assign tag_out = tag_q[SQ_STEPS-1];

endmodule

>>> hdl/bgd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgd_div
// Pipelined restoring divider, one quotient bit per stage. The quotient is
// known to fit in 32 bits. Divisor and a side tag travel with the data.
// ----------------------------------------------------------------------------
module bgd_div import bgd_pkg::*; #(
	parameter int TAG_W = 8
) (
	input  logic             clk,
	input  logic             en,
	input  logic [63:0]      num,
	input  logic [31:0]      den,
	input  logic [TAG_W-1:0] tag_in,
	output logic [31:0]      quo,
	output logic [31:0]      den_out,
	output logic [TAG_W-1:0] tag_out
);

	logic [63:0]      rem_q [DIV_STEPS];
	logic [31:0]      quo_q [DIV_STEPS];
	logic [31:0]      den_q [DIV_STEPS];
	logic [TAG_W-1:0] tag_q [DIV_STEPS];

	for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
		localparam int SH = DIV_STEPS - 1 - s;
		logic [63:0]      rem_i;
		logic [31:0]      quo_i;
		logic [31:0]      den_i;
		logic [TAG_W-1:0] tag_i;
		logic [63:0]      dsh;

		if (s == 0) begin : g_first
			assign rem_i = num;
			assign quo_i = '0;
			assign den_i = den;
			assign tag_i = tag_in;
		end else begin : g_next
			assign rem_i = rem_q[s-1];
			assign quo_i = quo_q[s-1];
			assign den_i = den_q[s-1];
			assign tag_i = tag_q[s-1];
		end

		assign dsh = {32'b0, den_i} << SH;

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_i >= dsh) begin
					rem_q[s] <= rem_i - dsh;
					quo_q[s] <= quo_i | (32'd1 << SH);
				end else begin
					rem_q[s] <= rem_i;
					quo_q[s] <= quo_i;
				end
				den_q[s] <= den_i;
				tag_q[s] <= tag_i;
			end
		end
	end

	assign quo     = quo_q[DIV_STEPS-1];
	assign den_out = den_q[DIV_STEPS-1];
	assign tag_out = tag_q[DIV_STEPS-1];

endmodule

>>> hdl/bgd_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgd_lane
// Force pipeline for one pair of bodies: gives the pull on each body by the
// other, both components, as signed terms plus coincidence flags.
// ----------------------------------------------------------------------------
module bgd_lane import bgd_pkg::*; (
	input  logic       clk,
	input  logic       en,
	input  pos_t       xa,
	input  pos_t       ya,
	input  pos_t       xb,
	input  pos_t       yb,
	input  mass_info_t mi_a,
	input  mass_info_t mi_b,
	output lane_res_t  res
);

	localparam int SQ_TAG_W  = 31 + 31 + 7 + 3;
	localparam int DIV_TAG_W = 9;
	localparam int CHAIN_N   = 4;

	function automatic logic [47:0] scale_term(logic [31:0] q, logic [5:0] pe,
		logic signed [6:0] k);
		logic signed [8:0] e;
		logic [63:0]       w;
		e = $signed({3'b0, pe}) - 9'sd14 - 9'(k) - 9'(k);
		if (e < 0) begin
			if (e < -9'sd31)
				w = '0;
			else
				w = {32'b0, q} >> 6'(-e);
		end else if (e > 9'sd31) begin
			w = (q != '0) ? 64'(MAG_CAP) : '0;
		end else begin
			w = {32'b0, q} << e[4:0];
		end
		return (w > 64'(MAG_CAP)) ? MAG_CAP : 48'(w);
	endfunction

	// stage 1: deltas
	logic signed [48:0] dx, dy;
	logic [47:0]        adx_s1, ady_s1;
	logic               negx_s1, negy_s1, zero_s1;

	assign dx = 49'(xb) - 49'(xa);
	assign dy = 49'(yb) - 49'(ya);

	always_ff @(posedge clk) begin
		if (en) begin
			adx_s1  <= 48'(dx[48] ? -dx : dx);
			ady_s1  <= 48'(dy[48] ? -dy : dy);
			negx_s1 <= dx[48];
			negy_s1 <= dy[48];
			zero_s1 <= (dx == '0) && (dy == '0);
		end
	end

	// stage 2: leading one of the larger magnitude
	logic [47:0] mx;
	logic [47:0] adx_s2, ady_s2;
	logic [5:0]  bl_s2;
	logic        negx_s2, negy_s2, zero_s2;

	assign mx = (adx_s1 > ady_s1) ? adx_s1 : ady_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			bl_s2   <= 6'(bitlen64({16'b0, mx}));
			adx_s2  <= adx_s1;
			ady_s2  <= ady_s1;
			negx_s2 <= negx_s1;
			negy_s2 <= negy_s1;
			zero_s2 <= zero_s1;
		end
	end

	// stage 3: normalize both components to 31 bits
	logic [30:0]       ux_s3, uy_s3;
	logic signed [6:0] k_s3;
	logic              negx_s3, negy_s3, zero_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			if (bl_s2 > 6'd31) begin
				ux_s3 <= 31'(adx_s2 >> (bl_s2 - 6'd31));
				uy_s3 <= 31'(ady_s2 >> (bl_s2 - 6'd31));
			end else begin
				ux_s3 <= 31'(adx_s2 << (6'd31 - bl_s2));
				uy_s3 <= 31'(ady_s2 << (6'd31 - bl_s2));
			end
			k_s3    <= $signed({1'b0, bl_s2}) - 7'sd31;
			negx_s3 <= negx_s2;
			negy_s3 <= negy_s2;
			zero_s3 <= zero_s2;
		end
	end

	// stage 4: squares
	logic [61:0]       sqx_s4, sqy_s4;
	logic [30:0]       ux_s4, uy_s4;
	logic signed [6:0] k_s4;
	logic              negx_s4, negy_s4, zero_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s4  <= 62'(ux_s3) * 62'(ux_s3);
			sqy_s4  <= 62'(uy_s3) * 62'(uy_s3);
			ux_s4   <= ux_s3;
			uy_s4   <= uy_s3;
			k_s4    <= k_s3;
			negx_s4 <= negx_s3;
			negy_s4 <= negy_s3;
			zero_s4 <= zero_s3;
		end
	end

	// stage 5: radicand
	logic [62:0]         rad_s5;
	logic [SQ_TAG_W-1:0] sq_tag_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s5    <= 63'(sqx_s4) + 63'(sqy_s4);
			sq_tag_s5 <= {ux_s4, uy_s4, k_s4, negx_s4, negy_s4, zero_s4};
		end
	end

	logic [31:0]         root;
	logic [SQ_TAG_W-1:0] sq_tag;

	bgd_isqrt #(.TAG_W(SQ_TAG_W)) u_isqrt (
		.clk     (clk),
		.en      (en),
		.rad     (rad_s5),
		.tag_in  (sq_tag_s5),
		.root    (root),
		.tag_out (sq_tag)
	);

	logic [30:0]       ux_r, uy_r;
	logic signed [6:0] k_r;
	logic              negx_r, negy_r, zero_r;

	assign {ux_r, uy_r, k_r, negx_r, negy_r, zero_r} = sq_tag;

	// stage 6: dividends; chains are a-x, a-y, b-x, b-y
	logic [63:0]          num_s6 [CHAIN_N];
	logic [DIV_TAG_W-1:0] dtag_s6 [CHAIN_N];
	logic [31:0]          r_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s6[0]  <= 64'(mi_b.pm) * 64'(ux_r);
			num_s6[1]  <= 64'(mi_b.pm) * 64'(uy_r);
			num_s6[2]  <= 64'(mi_a.pm) * 64'(ux_r);
			num_s6[3]  <= 64'(mi_a.pm) * 64'(uy_r);
			dtag_s6[0] <= {zero_r, negx_r, k_r};
			dtag_s6[1] <= {zero_r, negy_r, k_r};
			dtag_s6[2] <= {zero_r, ~negx_r, k_r};
			dtag_s6[3] <= {zero_r, ~negy_r, k_r};
			r_s6       <= root;
		end
	end

	logic [31:0]          q3 [CHAIN_N];
	logic [DIV_TAG_W-1:0] tag3 [CHAIN_N];

	for (genvar c = 0; c < CHAIN_N; c++) begin : g_chain
		logic [31:0]          q1, q2, r1, r2, r3;
		logic [DIV_TAG_W-1:0] t1, t2;

		bgd_div #(.TAG_W(DIV_TAG_W)) u_div1 (
			.clk     (clk),
			.en      (en),
			.num     (num_s6[c]),
			.den     (r_s6),
			.tag_in  (dtag_s6[c]),
			.quo     (q1),
			.den_out (r1),
			.tag_out (t1)
		);

		bgd_div #(.TAG_W(DIV_TAG_W)) u_div2 (
			.clk     (clk),
			.en      (en),
			.num     ({2'b0, q1, 30'b0}),
			.den     (r1),
			.tag_in  (t1),
			.quo     (q2),
			.den_out (r2),
			.tag_out (t2)
		);

		bgd_div #(.TAG_W(DIV_TAG_W)) u_div3 (
			.clk     (clk),
			.en      (en),
			.num     ({2'b0, q2, 30'b0}),
			.den     (r2),
			.tag_in  (t2),
			.quo     (q3[c]),
			.den_out (r3),
			.tag_out (tag3[c])
		);

		// stage 7: apply exponent and cap
		logic [47:0] mag_s7;
		logic        neg_s7, zero_s7;

		always_ff @(posedge clk) begin
			if (en) begin
				mag_s7  <= scale_term(q3[c], (c < 2) ? mi_b.pe : mi_a.pe,
					$signed(tag3[c][6:0]));
				neg_s7  <= tag3[c][7];
				zero_s7 <= tag3[c][8] | (r3 == '0);
			end
		end
	end

	// stage 8: sign, drop massless or coincident terms
	function automatic logic signed [48:0] signed_term(logic [47:0] mag, logic neg,
		logic keep);
		logic signed [48:0] t;
		t = $signed({1'b0, mag});
		if (!keep)
			return '0;
		return neg ? -t : t;
	endfunction

	lane_res_t res_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			res_s8.ax_a   <= signed_term(g_chain[0].mag_s7, g_chain[0].neg_s7,
				mi_b.nz & ~g_chain[0].zero_s7);
			res_s8.ay_a   <= signed_term(g_chain[1].mag_s7, g_chain[1].neg_s7,
				mi_b.nz & ~g_chain[1].zero_s7);
			res_s8.ax_b   <= signed_term(g_chain[2].mag_s7, g_chain[2].neg_s7,
				mi_a.nz & ~g_chain[2].zero_s7);
			res_s8.ay_b   <= signed_term(g_chain[3].mag_s7, g_chain[3].neg_s7,
				mi_a.nz & ~g_chain[3].zero_s7);
			res_s8.coin_a <= mi_b.nz & g_chain[0].zero_s7;
			res_s8.coin_b <= mi_a.nz & g_chain[0].zero_s7;
		end
	end

	assign res = res_s8;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gravity derivative testbench
// Drives three-body plane states through the derivative block, predicts the
// velocity copies and the summed pair pulls in integer arithmetic, and checks
// every result beat in order, with random stalls on both sides outside the quiet phase.
// ----------------------------------------------------------------------------
module testbench;
	import bgd_pkg::*;

	localparam int MASS_REG0 = 0;
	localparam int MASS_REG1 = 1;
	localparam int MASS_REG2 = 2;
	localparam int MASS_REG_UNUSED = 3;
	localparam int LATENCY = 137;
	localparam int STALL_LIMIT = 20000;
	localparam logic signed [63:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF;
	localparam logic signed [63:0] ACC_MIN = -64'sh8000_0000_0000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	item_t       item = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	result_t     result;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	logic [31:0] body_mass [3];
	bit          quiet_phase = 1'b0;
	bit          hold_off = 1'b0;
	bit          timed_out = 1'b0;
	int          idle_cycles = 0;

	always #5 clk = ~clk;

	nbody_gravity_derivative_top #(.BODY_COUNT(3)) u_dut (.*);

	function automatic int bit_length(logic [63:0] v);
		int n;
		n = 0;
		for (int b = 0; b < 64; b++)
			if (v[b]) n = b + 1;
		return n;
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] root, step;
		root = 0;
		step = 64'd1 << 62;
		while (step > v) step = step >> 2;
		while (step != 0) begin
			if (v >= root + step) begin
				v = v - (root + step);
				root = (root >> 1) + step;
			end else begin
				root = root >> 1;
			end
			step = step >> 2;
		end
		return root;
	endfunction

	function automatic logic [63:0] shift_by(logic [63:0] a, int k);
		if (k >= 0) return a >> k;
		return a << (-k);
	endfunction

	function automatic logic [63:0] pull_mag(logic [63:0] pm, int pe, logic [63:0] u,
			logic [63:0] r, int k);
		logic [63:0] q;
		int e;
		q = (pm * u) / r;
		q = (q << 30) / r;
		q = (q << 30) / r;
		e = pe - 14 - 2 * k;
		if (e < 0) q = (-e >= 64) ? 64'd0 : (q >> (-e));
		else if (e > 31) q = (q != 0) ? 64'(MAG_CAP) : 64'd0;
		else q = q << e;
		return (q > 64'(MAG_CAP)) ? 64'(MAG_CAP) : q;
	endfunction

	function automatic result_t derive_state(item_t s);
		result_t d;
		logic signed [63:0] px [3], py [3];
		logic signed [63:0] ax, ay, dx, dy, tx, ty;
		logic [63:0] p, pm, adx, ady, m, ux, uy, r;
		logic [47:0] acc [6];
		bit coincident;
		int pe, k;
		px[0] = s.body0_x; py[0] = s.body0_y;
		px[1] = s.body1_x; py[1] = s.body1_y;
		px[2] = s.body2_x; py[2] = s.body2_y;
		d.body0_dx = s.body0_vx; d.body0_dy = s.body0_vy;
		d.body1_dx = s.body1_vx; d.body1_dy = s.body1_vy;
		d.body2_dx = s.body2_vx; d.body2_dy = s.body2_vy;
		for (int i = 0; i < 3; i++) begin
			ax = 0; ay = 0; coincident = 0;
			for (int j = 0; j < 3; j++) begin
				if (j == i) continue;
				p = 64'(G_Q626) * 64'(body_mass[j]);
				if (p == 0) continue;
				dx = px[j] - px[i];
				dy = py[j] - py[i];
				if (dx == 0 && dy == 0) begin
					coincident = 1;
					continue;
				end
				pe = bit_length(p) - 32;
				pm = shift_by(p, pe);
				adx = (dx < 0) ? -dx : dx;
				ady = (dy < 0) ? -dy : dy;
				m = (adx > ady) ? adx : ady;
				k = bit_length(m) - 31;
				ux = shift_by(adx, k);
				uy = shift_by(ady, k);
				r = int_sqrt(ux * ux + uy * uy);
				if (r == 0) begin
					coincident = 1;
					continue;
				end
				tx = pull_mag(pm, pe, ux, r, k);
				ty = pull_mag(pm, pe, uy, r, k);
				ax += (dx < 0) ? -tx : tx;
				ay += (dy < 0) ? -ty : ty;
			end
			if (coincident) begin
				ax = ACC_MAX;
				ay = ACC_MAX;
			end
			if (ax > ACC_MAX) ax = ACC_MAX;
			if (ax < ACC_MIN) ax = ACC_MIN;
			if (ay > ACC_MAX) ay = ACC_MAX;
			if (ay < ACC_MIN) ay = ACC_MIN;
			acc[2 * i] = ax[47:0];
			acc[2 * i + 1] = ay[47:0];
		end
		d.body0_ax = acc[0]; d.body0_ay = acc[1];
		d.body1_ax = acc[2]; d.body1_ay = acc[3];
		d.body2_ax = acc[4]; d.body2_ay = acc[5];
		return d;
	endfunction

	class derivative_scoreboard;
		result_t pending[$];
		int      errors = 0;

		function void note_state(item_t s);
			pending.push_back(derive_state(s));
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result beat %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			for (int f = 0; f < 12; f++) begin
				if (want[575 - 48 * f -: 48] !== got[575 - 48 * f -: 48]) begin
					$display("%0t: field %0d expected %h actual %h", $time, f,
						want[575 - 48 * f -: 48], got[575 - 48 * f -: 48]);
					errors++;
				end
			end
		endfunction
	endclass

	derivative_scoreboard board = new();

	always @(posedge clk) begin
		if (item_valid && item_ready) board.note_state(item);
		if (result_valid && result_ready) board.check_result(result);
		if ((item_valid && item_ready) || (result_valid && result_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	always @(posedge clk) begin
		if (idle_cycles >= STALL_LIMIT && !timed_out) begin
			timed_out = 1;
			$display("testbench: FAIL");
			$finish;
		end
	end

	// receiver: random stall bursts, or a long hold-off when asked
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				result_ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_off = 0;
			end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
				gap = $urandom_range(1, 4);
				result_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end else begin
				result_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic write_mass(int idx, logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_index <= 2'(idx);
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx < 3) body_mass[idx] = value;
	endtask

	task automatic send_state(item_t s);
		int gap;
		if (!quiet_phase && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 4);
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= s;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	function automatic logic [47:0] rand48();
		return {16'($urandom()), 32'($urandom())};
	endfunction

	// mostly near-orbit positions, sometimes full-range or clustered values
	function automatic logic [47:0] rand_pos();
		logic signed [47:0] v;
		case ($urandom_range(0, 5))
			0: v = rand48();
			1: v = $signed(48'($urandom_range(0, 15)) - 48'd8);
			2: v = $signed({{16{1'b0}}, 32'($urandom())}) - 48'sh8000_0000;
			default: v = $signed({{12{1'b0}}, 4'($urandom()), 32'($urandom())})
				- 48'sh8_0000_0000;
		endcase
		return v;
	endfunction

	function automatic item_t rand_state();
		item_t s;
		s.body0_x = rand_pos(); s.body0_y = rand_pos();
		s.body1_x = rand_pos(); s.body1_y = rand_pos();
		s.body2_x = rand_pos(); s.body2_y = rand_pos();
		if ($urandom_range(0, 15) == 0) begin
			s.body1_x = s.body0_x;
			s.body1_y = s.body0_y;
		end
		if ($urandom_range(0, 15) == 0) s.body2_x = s.body1_x;
		s.body0_vx = rand48(); s.body0_vy = rand48();
		s.body1_vx = rand48(); s.body1_vy = rand48();
		s.body2_vx = rand48(); s.body2_vy = rand48();
		return s;
	endfunction

	function automatic item_t plain_state(logic [47:0] a, logic [47:0] b, logic [47:0] c);
		item_t s;
		s = '0;
		s.body0_x = a; s.body1_y = b; s.body2_x = c; s.body2_y = -c;
		s.body0_vx = a; s.body1_vy = b; s.body2_vx = c; s.body2_vy = ~c;
		return s;
	endfunction

	function automatic logic [31:0] rand_mass();
		case ($urandom_range(0, 4))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return 32'($urandom());
			default: return 32'($urandom_range(1, 1 << 25));
		endcase
	endfunction

	initial begin
		body_mass[0] = 32'd16777216;
		body_mass[1] = 32'd16777216;
		body_mass[2] = 32'd16777216;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, coincident bodies, close and far pairs
		send_state(plain_state(48'sh0001_0000_0000, 48'sh0002_0000_0000, 48'sh0003_0000_0000));
		send_state(plain_state(48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h0));
		send_state(plain_state(48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF));
		send_state(plain_state(48'h1, 48'hFFFF_FFFF_FFFF, 48'h2));
		send_state('0);
		send_state('1);
		send_state(plain_state(48'h0, 48'h0, 48'h1));
		send_state(plain_state(48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 48'h1234_5678_9ABC));
		for (int n = 0; n < 6; n++) send_state(rand_state());
		drain();

		// zero mass on one body, extremes on the others, unused index ignored
		write_mass(MASS_REG0, 32'd0);
		write_mass(MASS_REG1, 32'hFFFF_FFFF);
		write_mass(MASS_REG2, 32'd1);
		write_mass(MASS_REG_UNUSED, 32'hDEAD_BEEF);
		send_state('0);
		send_state(plain_state(48'h1, 48'h0, 48'h7FFF_FFFF_FFFF));
		for (int n = 0; n < 8; n++) send_state(rand_state());
		drain();

		for (int phase = 0; phase < 8; phase++) begin
			write_mass(MASS_REG0, rand_mass());
			write_mass(MASS_REG1, rand_mass());
			write_mass(MASS_REG2, rand_mass());
			if (phase == 3) hold_off = 1;
			if (phase == 7) quiet_phase = 1;
			for (int n = 0; n < 228; n++) send_state(rand_state());
			drain();
		end

		if (board.errors == 0 && board.pending.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end
endmodule
